// File: hw/rtl/bmg_pkg.sv
`timescale 1ns / 1ps
// Package for the Box-Muller Gaussian pair generator.
// Constants and shared functions; no dependencies.
package bmg_pkg;
	localparam logic [30:0] TwoLn2Q30  = 31'd1488522236;
	localparam logic [30:0] HalfPiQ30  = 31'd1686629713;
	localparam logic [30:0] Q30One     = 31'h4000_0000;
	localparam logic [19:0] RadiusMax  = 20'hFFFFF;

	function automatic logic [7:0] sin_div(input int i);
		case (i)
			0: sin_div = 8'd156;
			1: sin_div = 8'd110;
			2: sin_div = 8'd72;
			3: sin_div = 8'd42;
			4: sin_div = 8'd20;
			default: sin_div = 8'd6;
		endcase
	endfunction

	function automatic logic [7:0] cos_div(input int i);
		case (i)
			0: cos_div = 8'd182;
			1: cos_div = 8'd132;
			2: cos_div = 8'd90;
			3: cos_div = 8'd56;
			4: cos_div = 8'd30;
			5: cos_div = 8'd12;
			default: cos_div = 8'd2;
		endcase
	endfunction
endpackage

// File: hw/rtl/box_muller_gaussian_pair_top.sv
`timescale 1ns / 1ps
// Box-Muller Gaussian pair: one beat accepted every cycle (busy is tied low,
// results are never held off). Pipeline length is set by the radius path,
// chiefly its 32-stage log and 20-stage square-root pipelines.
// Reset clears the valid chain only.
// Depends on bmg_pkg, bmg_radius, bmg_trig, bmg_scale.
module box_muller_gaussian_pair_top #(
	parameter int IN_BITS       = 32,
	parameter int OUT_FRAC_BITS = 12
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	output logic               busy,
	input  logic [31:0]        uniform_radius,
	input  logic [31:0]        uniform_angle,
	output logic               strobe,
	output logic signed [15:0] normal_sine,
	output logic signed [15:0] normal_cosine
);
	localparam int RLat = 55;
	localparam int TLat = 11;
	localparam int Lat  = RLat + 2;

	assign busy = 1'b0;

	logic [19:0] r;
	bmg_radius #(.IN_BITS(IN_BITS)) u_rad (
		.clk(clk), .x(IN_BITS'(uniform_radius)), .r(r)
	);

	// delay angle so trig result lines up with radius
	logic [IN_BITS-1:0] ad_q [RLat-TLat+1];
	assign ad_q[0] = IN_BITS'(uniform_angle);
	for (genvar g = 0; g < RLat - TLat; g++) begin : g_ad
		always_ff @(posedge clk) ad_q[g+1] <= ad_q[g];
	end

	logic [30:0] s0, c0;
	logic [1:0]  quad;
	bmg_trig #(.IN_BITS(IN_BITS)) u_trig (
		.clk(clk), .ang(ad_q[RLat-TLat]), .s0(s0), .c0(c0), .quad(quad)
	);

	logic [30:0] smag, cmag;
	logic        sneg, cneg;
	always_comb begin
		case (quad)
			2'd0: begin smag = s0; sneg = 1'b0; cmag = c0; cneg = 1'b0; end
			2'd1: begin smag = c0; sneg = 1'b0; cmag = s0; cneg = 1'b1; end
			2'd2: begin smag = s0; sneg = 1'b1; cmag = c0; cneg = 1'b1; end
			default: begin smag = c0; sneg = 1'b1; cmag = s0; cneg = 1'b0; end
		endcase
	end

	bmg_scale #(.OUT_FRAC_BITS(OUT_FRAC_BITS)) u_ss (
		.clk(clk), .r(r), .mag(smag), .neg(sneg), .z(normal_sine)
	);
	bmg_scale #(.OUT_FRAC_BITS(OUT_FRAC_BITS)) u_sc (
		.clk(clk), .r(r), .mag(cmag), .neg(cneg), .z(normal_cosine)
	);

	logic [Lat-1:0] vld_q;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) vld_q <= '0;
		else vld_q <= {vld_q[Lat-2:0], start};
	end
	assign strobe = vld_q[Lat-1];
endmodule

// File: hw/rtl/bmg_radius.sv
`timescale 1ns / 1ps
// Radius pipeline: r = floor(sqrt(-2 ln u1)) in Q.16.
// Depends on bmg_pkg. One log bit per stage, then one root bit per stage.
module bmg_radius #(
	parameter int IN_BITS = 32
) (
	input  logic               clk,
	input  logic [IN_BITS-1:0] x,
	output logic [19:0]        r
);
	localparam int EW = $clog2(IN_BITS + 1);

	// normalize
	logic [31:0]   m_s1;
	logic [EW-1:0] e_s1;
	logic          z_s1;
	logic [31:0]   mn;
	logic [EW-1:0] en;
	always_comb begin
		en = '0;
		for (int i = 0; i < IN_BITS; i++)
			if (x[i]) en = EW'(i);
		mn = 32'((64'(x) << 31) >> en);
	end
	always_ff @(posedge clk) begin
		m_s1 <= mn;
		e_s1 <= en;
		z_s1 <= (x == '0);
	end

	// 32 squaring stages
	logic [31:0]   lm [33];
	logic [31:0]   lf [33];
	logic [EW-1:0] le [33];
	logic          lz [33];
	assign lm[0] = m_s1;
	assign lf[0] = '0;
	assign le[0] = e_s1;
	assign lz[0] = z_s1;
	for (genvar g = 0; g < 32; g++) begin : g_log
		logic [63:0] sq;
		assign sq = 64'(lm[g]) * 64'(lm[g]);
		always_ff @(posedge clk) begin
			lm[g+1] <= sq[63] ? sq[63:32] : sq[62:31];
			lf[g+1] <= {lf[g][30:0], sq[63]};
			le[g+1] <= le[g];
			lz[g+1] <= lz[g];
		end
	end

	// scale by 2 ln2; -log2 kept as Q.24
	logic [29:0] l_s2;
	logic [41:0] s_s3;
	logic        z_s2, z_s3;
	always_ff @(posedge clk) begin
		l_s2 <= 30'((((64'(IN_BITS) - 64'(le[32])) << 32) - 64'(lf[32])) >> 8);
		z_s2 <= lz[32];
		s_s3 <= 42'((64'(l_s2) * 64'(bmg_pkg::TwoLn2Q30) + 64'd2097152) >> 22);
		z_s3 <= z_s2;
	end

	// restoring sqrt, 20 result bits, value below 2^40
	logic [41:0] rv [21];
	logic [19:0] rr [21];
	logic        rz [21];
	assign rv[0] = s_s3;
	assign rr[0] = '0;
	assign rz[0] = z_s3;
	for (genvar g = 0; g < 20; g++) begin : g_sq
		localparam int B = 19 - g;
		logic [41:0] trial;
		assign trial = (42'(rr[g]) << (B + 1)) + (42'd1 << (2 * B));
		always_ff @(posedge clk) begin
			rz[g+1] <= rz[g];
			if (rv[g] >= trial) begin
				rv[g+1] <= rv[g] - trial;
				rr[g+1] <= rr[g] | (20'd1 << B);
			end else begin
				rv[g+1] <= rv[g];
				rr[g+1] <= rr[g];
			end
		end
	end

	assign r = rz[20] ? bmg_pkg::RadiusMax : rr[20];
endmodule

// File: hw/rtl/bmg_trig.sv
`timescale 1ns / 1ps
// Trig pipeline: quarter-turn angle, Horner sin/cos series, one term per stage.
// Depends on bmg_pkg.
module bmg_trig #(
	parameter int IN_BITS = 32
) (
	input  logic               clk,
	input  logic [IN_BITS-1:0] ang,
	output logic [30:0]        s0,
	output logic [30:0]        c0,
	output logic [1:0]         quad
);
	logic [31:0] p;
	assign p = (IN_BITS >= 32) ? 32'(64'(ang) >> (IN_BITS - 32))
	                           : 32'(64'(ang) << (32 - IN_BITS));

	logic [30:0] a_s1, a_s2, a_s3;
	logic [31:0] a2_s2, a2_s3;
	logic [1:0]  q_s1, q_s2, q_s3;
	logic [60:0] ap;
	logic [61:0] aa;
	assign ap = 61'(p[29:0]) * 61'(bmg_pkg::HalfPiQ30);
	assign aa = 62'(a_s1) * 62'(a_s1);
	always_ff @(posedge clk) begin
		a_s1  <= ap[60:30];
		q_s1  <= p[31:30];
		a_s2  <= a_s1;
		a2_s2 <= aa[61:30];
		q_s2  <= q_s1;
		a_s3  <= a_s2;
		a2_s3 <= a2_s2;
		q_s3  <= q_s2;
	end

	logic [31:0] ta [6];
	logic [30:0] tb [8];
	logic [1:0]  tq [8];
	logic [30:0] ys [8];
	logic [30:0] yc [8];
	logic [30:0] qs [6];
	logic [30:0] qc [7];
	logic [30:0] qsn [6];
	logic [30:0] qcn [7];

	// floor(a2 / k) as (a2 * M) >> S, exact for a2 below 2^32;
	// each quotient is formed one stage ahead of its Horner term
	for (genvar j = 0; j < 7; j++) begin : g_q
		localparam logic [63:0] KC = 64'(bmg_pkg::cos_div(j));
		localparam int          SC = 32 + $clog2(KC);
		localparam logic [63:0] MC = ((64'd1 << SC) + KC - 64'd1) / KC;
		logic [31:0] src;
		logic [95:0] pqc;
		if (j == 0) begin : g_first
			assign src = a2_s2;
		end else begin : g_next
			assign src = ta[j-1];
		end
		assign pqc = 96'(src) * 96'(MC);
		assign qcn[j] = 31'(pqc >> SC);
		if (j < 6) begin : g_sin
			localparam logic [63:0] KS = 64'(bmg_pkg::sin_div(j));
			localparam int          SS = 32 + $clog2(KS);
			localparam logic [63:0] MS = ((64'd1 << SS) + KS - 64'd1) / KS;
			logic [95:0] pqs;
			assign pqs = 96'(src) * 96'(MS);
			assign qsn[j] = 31'(pqs >> SS);
		end
	end

	always_ff @(posedge clk) begin
		qs[0] <= qsn[0];
		qc[0] <= qcn[0];
	end

	assign ys[0] = bmg_pkg::Q30One;
	assign yc[0] = bmg_pkg::Q30One;
	assign ta[0] = a2_s3;
	assign tb[0] = a_s3;
	assign tq[0] = q_s3;
	for (genvar g = 0; g < 7; g++) begin : g_h
		logic [61:0] pc;
		assign pc = 62'(qc[g]) * 62'(yc[g]);
		always_ff @(posedge clk) begin
			tb[g+1] <= tb[g];
			tq[g+1] <= tq[g];
			yc[g+1] <= (pc[61:30] >= 32'(bmg_pkg::Q30One)) ? '0
			           : bmg_pkg::Q30One - pc[60:30];
		end
		if (g < 6) begin : g_sin
			logic [61:0] ps;
			assign ps = 62'(qs[g]) * 62'(ys[g]);
			always_ff @(posedge clk) begin
				ys[g+1] <= (ps[61:30] >= 32'(bmg_pkg::Q30One)) ? '0
				           : bmg_pkg::Q30One - ps[60:30];
				qc[g+1] <= qcn[g+1];
			end
		end else begin : g_pass
			always_ff @(posedge clk) ys[g+1] <= ys[g];
		end
		if (g < 5) begin : g_fwd
			always_ff @(posedge clk) begin
				ta[g+1] <= ta[g];
				qs[g+1] <= qsn[g+1];
			end
		end
	end

	logic [61:0] sp;
	assign sp = 62'(tb[7]) * 62'(ys[7]);
	always_ff @(posedge clk) begin
		s0   <= sp[60:30];
		c0   <= yc[7];
		quad <= tq[7];
	end
endmodule

// File: hw/rtl/bmg_scale.sv
`timescale 1ns / 1ps
// Output scaling: r times trig magnitude, round, sign, saturate. Two stages.
// Depends on bmg_pkg.
module bmg_scale #(
	parameter int OUT_FRAC_BITS = 12
) (
	input  logic               clk,
	input  logic [19:0]        r,
	input  logic [30:0]        mag,
	input  logic               neg,
	output logic signed [15:0] z
);
	localparam int Sh = 46 - OUT_FRAC_BITS;
	logic [50:0] p_s1;
	logic        n_s1;
	logic [50:0] v;
	always_comb v = (p_s1 + (51'd1 << (Sh - 1))) >> Sh;
	always_ff @(posedge clk) begin
		p_s1 <= 51'(r) * 51'(mag);
		n_s1 <= neg;
		if (!n_s1)
			z <= (v > 51'd32767) ? 16'sd32767 : 16'(v);
		else
			z <= (v > 51'd32768) ? 16'sh8000 : 16'(17'h10000 - 17'(v));
	end
endmodule

// File: hw/rtl/bmg_checker.sv
`timescale 1ns / 1ps
// Port-level checker for the Gaussian pair top; bound below.
// Depends on nothing but the top-level ports.
module bmg_checker (
	input logic clk,
	input logic arst_n,
	input logic start,
	input logic busy,
	input logic strobe
);
	a_nobusy: assert property (@(posedge clk) disable iff (!arst_n) !busy)
		else $error("busy raised");
	a_lat: assert property (@(posedge clk) disable iff (!arst_n)
		start |-> ##57 strobe) else $error("result beat missing");
	a_nospur: assert property (@(posedge clk) disable iff (!arst_n)
		strobe |-> $past(start, 57)) else $error("spurious result beat");
endmodule

bind box_muller_gaussian_pair_top bmg_checker u_chk (
	.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .strobe(strobe)
);

// File: sim/tb_box_muller_gaussian_pair_top.sv
`timescale 1ns / 1ps
// Testbench for box_muller_gaussian_pair_top: directed corners, then random phases,
// some with sender gaps; a scoreboard predicts each Gaussian pair bit exactly.
// Depends on bmg_pkg and the block's RTL.
module tb_box_muller_gaussian_pair_top;
	localparam int CycleLimit = 400000;

	class gauss_scoreboard;
		logic signed [15:0] exp_sine[$];
		logic signed [15:0] exp_cosine[$];
		int errors;
		int checked;

		function automatic logic [63:0] isqrt(logic [63:0] v);
			logic [63:0] res;
			logic [63:0] bt;
			res = 0;
			bt = 64'd1 << 62;
			while (bt > v) bt = bt >> 2;
			while (bt != 0) begin
				if (v >= res + bt) begin
					v = v - (res + bt);
					res = (res >> 1) + bt;
				end else begin
					res = res >> 1;
				end
				bt = bt >> 2;
			end
			return res;
		endfunction

		function automatic logic [63:0] radius(logic [31:0] x);
			int e;
			logic [63:0] m, sq, frac, lq, s;
			if (x == 0) return {44'd0, bmg_pkg::RadiusMax};
			e = 31;
			while (e > 0 && !x[e]) e--;
			m = {32'd0, x} << (31 - e);
			frac = 0;
			for (int i = 31; i >= 0; i--) begin
				sq = m * m;
				if (sq[63]) begin
					frac[i] = 1'b1;
					m = sq >> 32;
				end else begin
					m = sq >> 31;
				end
			end
			lq = (64'(32 - e) << 32) - frac;
			s = ((lq >> 8) * 64'(bmg_pkg::TwoLn2Q30) + (64'd1 << 21)) >> 22;
			return isqrt(s);
		endfunction

		function automatic logic [63:0] horner(logic [63:0] a2, logic [63:0] k,
				logic [63:0] y);
			logic [63:0] t;
			t = ((a2 / k) * y) >> 30;
			return (t >= 64'(bmg_pkg::Q30One)) ? 64'd0 : 64'(bmg_pkg::Q30One) - t;
		endfunction

		function automatic logic signed [15:0] scale(logic [63:0] r, logic [63:0] mag,
				bit neg);
			logic [63:0] v;
			v = (r * mag + (64'd1 << 33)) >> 34;
			if (!neg) return (v > 32767) ? 16'sd32767 : 16'(v);
			if (v > 32768) v = 32768;
			return 16'(17'h10000 - v[16:0]);
		endfunction

		function void note_input(logic [31:0] u_rad, logic [31:0] u_ang);
			logic [63:0] r, a, a2, ys, yc, s0, c0, smag, cmag;
			logic [63:0] sdiv[6];
			logic [63:0] cdiv[7];
			bit sneg, cneg;
			sdiv = '{156, 110, 72, 42, 20, 6};
			cdiv = '{182, 132, 90, 56, 30, 12, 2};
			r = radius(u_rad);
			a = ({34'd0, u_ang[29:0]} * 64'(bmg_pkg::HalfPiQ30)) >> 30;
			a2 = (a * a) >> 30;
			ys = 64'(bmg_pkg::Q30One);
			foreach (sdiv[i]) ys = horner(a2, sdiv[i], ys);
			s0 = (a * ys) >> 30;
			yc = 64'(bmg_pkg::Q30One);
			for (int i = 0; i < 6; i++) yc = horner(a2, cdiv[i], yc);
			c0 = horner(a2, cdiv[6], yc);
			case (u_ang[31:30])
				2'd0: begin smag = s0; sneg = 0; cmag = c0; cneg = 0; end
				2'd1: begin smag = c0; sneg = 0; cmag = s0; cneg = 1; end
				2'd2: begin smag = s0; sneg = 1; cmag = c0; cneg = 1; end
				default: begin smag = c0; sneg = 1; cmag = s0; cneg = 0; end
			endcase
			exp_sine = {exp_sine, scale(r, smag, sneg)};
			exp_cosine = {exp_cosine, scale(r, cmag, cneg)};
		endfunction

		task report(string msg);
			$display("mismatch: %s", msg);
			errors++;
		endtask

		task check_result(logic signed [15:0] sn, logic signed [15:0] cs);
			logic signed [15:0] es, ec;
			if (exp_sine.size() == 0) begin
				report($sformatf("unexpected beat sine=%0d cosine=%0d", sn, cs));
				return;
			end
			es = exp_sine.pop_front();
			ec = exp_cosine.pop_front();
			if (sn !== es)
				report($sformatf("beat %0d sine got %0d want %0d", checked, sn, es));
			if (cs !== ec)
				report($sformatf("beat %0d cosine got %0d want %0d", checked, cs, ec));
			checked++;
		endtask

		function int pending();
			return exp_sine.size();
		endfunction
	endclass

	logic clk = 0;
	logic arst_n = 0;
	logic start = 0;
	logic [31:0] uniform_radius = 0;
	logic [31:0] uniform_angle = 0;
	logic busy, strobe;
	logic signed [15:0] normal_sine, normal_cosine;
	gauss_scoreboard sb = new();
	int cycles = 0;
	int sent = 0;
	int idle_pct = 0;

	box_muller_gaussian_pair_top dut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
		.uniform_radius(uniform_radius), .uniform_angle(uniform_angle),
		.strobe(strobe), .normal_sine(normal_sine), .normal_cosine(normal_cosine)
	);

	always begin
		#4 clk = 1;
		#4 clk = 0;
	end

	always @(posedge clk) begin
		cycles++;
		if (strobe) sb.check_result(normal_sine, normal_cosine);
		if (cycles > CycleLimit) begin
			$display("timeout after %0d cycles", cycles);
			$display("RESULT: ERROR");
			$finish;
		end
	end

	// Drives one beat starting at a falling edge; leaves start high afterwards.
	task send_beat(logic [31:0] ur, logic [31:0] ua);
		while ($urandom_range(99) < idle_pct) begin
			@(negedge clk);
			start = 0;
		end
		@(negedge clk);
		start = 1;
		uniform_radius = ur;
		uniform_angle = ua;
		do @(posedge clk); while (busy);
		sb.note_input(ur, ua);
		sent++;
	endtask

	task drain();
		@(negedge clk);
		start = 0;
		while (sb.pending() > 0) @(posedge clk);
	endtask

	function automatic logic [31:0] pick_radius();
		case ($urandom_range(9))
			0: return 32'd0;
			1: return 32'd1 << $urandom_range(31);
			2: return $urandom_range(255);
			3: return 32'hFFFFFFFF - $urandom_range(255);
			4: return $urandom >> $urandom_range(31);
			default: return $urandom;
		endcase
	endfunction

	function automatic logic [31:0] pick_angle();
		logic [31:0] v;
		v = $urandom;
		case ($urandom_range(7))
			0: v[29:0] = 30'(32'h3FFFFFFF - $urandom_range(1023));
			1: v[29:0] = 30'($urandom_range(1023));
			default: ;
		endcase
		return v;
	endfunction

	initial begin
		logic [31:0] rads[8];
		logic [31:0] angs[4];
		rads = '{32'd0, 32'd1, 32'd2, 32'h8000_0000, 32'hFFFF_FFFF, 32'h0000_FFFF,
			32'h5555_5555, 32'hAAAA_AAAA};
		angs = '{32'h0000_0000, 32'h4000_0000, 32'h8000_0000, 32'hC000_0000};
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n = 1;
		foreach (rads[i]) send_beat(rads[i], angs[i % 4]);
		send_beat(32'h0001_0000, 32'hFFFF_FFFF);
		send_beat(32'h0000_0000, 32'h3FFF_FFFF);
		send_beat(32'h0000_0000, 32'h0000_0001);
		send_beat(32'h7FFF_FFFF, 32'h7FFF_FFFF);
		send_beat(32'h0000_0010, 32'hBFFF_FFFF);
		send_beat(32'hFFFF_FFFE, 32'h2000_0000);
		drain();
		foreach (angs[p]) begin
			idle_pct = (p == 0) ? 0 : (p == 1) ? 51 : (p == 2) ? 0 : 22;
			repeat (258) send_beat(pick_radius(), pick_angle());
			if (p != 3) drain();
		end
		drain();
		repeat (70) @(posedge clk);
		$display("sent %0d beats over idle-free and gapped phases, checked %0d results",
			sent, sb.checked);
		$display("covered zero and extreme radii, all quadrants and quarter-turn edges");
		if (sb.errors == 0 && sb.pending() == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end
endmodule

// File: files.f
hw/rtl/bmg_pkg.sv
hw/rtl/bmg_radius.sv
hw/rtl/bmg_trig.sv
hw/rtl/bmg_scale.sv
hw/rtl/box_muller_gaussian_pair_top.sv
hw/rtl/bmg_checker.sv
sim/tb_box_muller_gaussian_pair_top.sv
